// ----- hdl/q15fir_pkg.sv -----
// ----------------------------------------------------------------------------
// q15fir_pkg
// Shared types and codes of the streaming Q15 FIR: beat payloads, command and
// register codes, cell and accumulator controls, sequencer states.
// ----------------------------------------------------------------------------
package q15fir_pkg;

   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_COEF   = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_ADDR_W-1:0] CSR_TAP_COUNT = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IO_FORMAT = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADC_MID   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_DAC_MID   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_DAC_MAX   = 3'd4;

   localparam logic signed [15:0] Q15_MAX = 16'sh7FFF;
   localparam logic signed [15:0] Q15_MIN = 16'sh8000;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [11:0]        adc_code;
      logic signed [15:0] q15_in;
      logic [6:0]         coeff_index;
      logic signed [15:0] coeff_value;
   } req_type;

   typedef struct packed {
      logic signed [15:0] q15_out;
      logic [11:0]        dac_code;
   } rsp_type;

   typedef enum logic [1:0] {
      SAMP_HOLD,
      SAMP_SHIFT,
      SAMP_ROTATE,
      SAMP_CLEAR
   } samp_op_type;

   typedef enum logic [1:0] {
      COEF_HOLD,
      COEF_ROTATE,
      COEF_WRITE
   } coef_op_type;

   typedef struct packed {
      samp_op_type samp_op;
      coef_op_type coef_op;
   } cell_ctrl_type;

   typedef struct packed {
      logic clear;
      logic term;
   } mac_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_MAC,
      ST_DRAIN,
      ST_SCALE,
      ST_DONE
   } state_type;

endpackage

// ----- hdl/q15fir_cell.sv -----
// ----------------------------------------------------------------------------
// q15fir_cell
// One tap cell: one history sample and one coefficient. Samples shift in,
// rotate toward cell zero or clear; coefficients rotate away from cell zero
// or take a write addressed to this cell's position.
// ----------------------------------------------------------------------------
module q15fir_cell
   import q15fir_pkg::*;
#(
   parameter int IDX_W = 7,
   parameter int POS   = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctrl_type        ctrl,
   input  logic [IDX_W-1:0]     wr_pos,
   input  logic signed [15:0]   wr_data,
   input  logic signed [15:0]   samp_prev,
   input  logic signed [15:0]   samp_next,
   input  logic signed [15:0]   coef_prev,
   output logic signed [15:0]   samp_q,
   output logic signed [15:0]   coef_q
);

   localparam logic [IDX_W-1:0] MY_POS = IDX_W'(POS);

   logic signed [15:0] samp_ff, samp_in;
   logic signed [15:0] coef_ff, coef_in;

   always_comb begin
      case (ctrl.samp_op)
         SAMP_SHIFT:  samp_in = samp_prev;
         SAMP_ROTATE: samp_in = samp_next;
         SAMP_CLEAR:  samp_in = '0;
         default:     samp_in = samp_ff;
      endcase
   end

   always_comb begin
      case (ctrl.coef_op)
         COEF_ROTATE: coef_in = coef_prev;
         COEF_WRITE:  coef_in = (wr_pos == MY_POS) ? wr_data : coef_ff;
         default:     coef_in = coef_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         samp_ff <= '0;
         coef_ff <= '0;
      end else begin
         samp_ff <= samp_in;
         coef_ff <= coef_in;
      end
   end

   assign samp_q = samp_ff;
   assign coef_q = coef_ff;

endmodule

// ----- hdl/q15fir_mac.sv -----
// ----------------------------------------------------------------------------
// q15fir_mac
// Shared multiply-accumulate: registered 16x16 product, then a wide
// accumulator that adds the product of every active term.
// ----------------------------------------------------------------------------
module q15fir_mac
   import q15fir_pkg::*;
#(
   parameter int ACC_W = 39
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mac_ctrl_type             ctrl,
   input  logic signed [15:0]       samp,
   input  logic signed [15:0]       coef,
   output logic signed [ACC_W-1:0]  acc
);

   logic signed [31:0]      prod_ff, prod_in;
   logic                    pv_ff, pv_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   always_comb begin
      prod_in = $signed({{16{samp[15]}}, samp}) * $signed({{16{coef[15]}}, coef});
      pv_in   = ctrl.term && !ctrl.clear;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (pv_ff) begin
         acc_in = acc_ff + $signed({{(ACC_W-32){prod_ff[31]}}, prod_ff});
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         pv_ff  <= 1'b0;
         acc_ff <= '0;
      end else begin
         pv_ff  <= pv_in;
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// ----- hdl/q15_fir_adc_dac_stream.sv -----
// ----------------------------------------------------------------------------
// q15_fir_adc_dac_stream
// Streaming Q15 direct-form FIR with ADC12 input conversion and DAC12 output.
// ----------------------------------------------------------------------------
// A sample beat (tap_count not zero) passes the ALIGN, MAC, DRAIN, SCALE and DONE
// states and presents its result once the output register is free; the block
// takes the next beat in the same cycle that the result is presented, not before.
// The length of the MAC pass is set by the row of MAX_TAPS tap cells, which
// rotates its samples past a single shared multiplier once per sample, one
// tap per cycle. The first sample after a tap_count change first realigns
// the coefficient ring in ALIGN. Coefficient writes, history clears, unused
// commands and samples dropped at zero taps keep the block idle and ready
// and give no result. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module q15_fir_adc_dac_stream
   import q15fir_pkg::*;
#(
   parameter int MAX_TAPS = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_item,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(MAX_TAPS);
   localparam int TW    = (IDX_W + 1 > 8) ? IDX_W + 1 : 8;
   localparam int ACC_W = 32 + IDX_W;
   localparam int SH_W  = ACC_W - 15;
   localparam logic [IDX_W-1:0]      LAST_POS = IDX_W'(MAX_TAPS - 1);
   localparam logic [TW-1:0]         TAP_LIM  = TW'(MAX_TAPS);
   localparam logic signed [SH_W-1:0] SH_MAX  = SH_W'(32767);
   localparam logic signed [SH_W-1:0] SH_MIN  = SH_W'(-32768);

   // configuration
   logic [7:0]  tap_count_ff;
   logic        io_format_ff;
   logic [11:0] adc_mid_ff, dac_mid_ff, dac_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= 8'd0;
         io_format_ff <= 1'b0;
         adc_mid_ff   <= 12'd2048;
         dac_mid_ff   <= 12'd2048;
         dac_max_ff   <= 12'd4095;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_TAP_COUNT: tap_count_ff <= csr_wdata[7:0];
            CSR_IO_FORMAT: io_format_ff <= csr_wdata[0];
            CSR_ADC_MID:   adc_mid_ff   <= csr_wdata[11:0];
            CSR_DAC_MID:   dac_mid_ff   <= csr_wdata[11:0];
            CSR_DAC_MAX:   dac_max_ff   <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // control state
   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   rot_ff, rot_in;
   logic signed [15:0] y_ff, y_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_item_ff, rsp_item_in;

   logic               accept, taps_zero, aligned, out_free, coef_ok;
   logic [TW-1:0]      tc_ext, taps_sat;
   logic [IDX_W-1:0]   rot_tgt;
   logic [IDX_W+6:0]   idx_wide;
   logic [IDX_W:0]     idx_a, rot_b, phys;
   logic [IDX_W-1:0]   wr_pos;
   logic signed [12:0] adc_diff;
   logic signed [15:0] x_new;
   cell_ctrl_type      cell_ctrl;
   mac_ctrl_type       mac_ctrl;
   logic signed [ACC_W-1:0] acc;
   logic signed [SH_W-1:0]  shr;
   logic [14:0]        dac_sum;
   logic [11:0]        dac_code;

   assign accept    = req_valid && req_ready;
   assign taps_zero = (tap_count_ff == 8'd0);
   assign tc_ext    = TW'(tap_count_ff);
   assign taps_sat  = (tc_ext > TAP_LIM) ? TAP_LIM : tc_ext;
   assign rot_tgt   = IDX_W'(taps_sat - TW'(1));
   assign aligned   = (rot_ff == rot_tgt);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // coefficient index to physical cell: cell p holds coeff[(p + rot) mod MAX_TAPS]
   assign idx_wide = (IDX_W+7)'(req_item.coeff_index);
   assign coef_ok  = (idx_wide < (IDX_W+7)'(MAX_TAPS));
   assign idx_a    = {1'b0, idx_wide[IDX_W-1:0]};
   assign rot_b    = {1'b0, rot_ff};
   assign phys     = (idx_a >= rot_b) ? (idx_a - rot_b)
                                      : (idx_a + (IDX_W+1)'(MAX_TAPS) - rot_b);
   assign wr_pos   = phys[IDX_W-1:0];

   // input sample conversion
   assign adc_diff = $signed({1'b0, req_item.adc_code}) - $signed({1'b0, adc_mid_ff});
   always_comb begin
      if (io_format_ff) begin
         x_new = req_item.q15_in;
      end else if (adc_diff[12] != adc_diff[11]) begin
         x_new = adc_diff[12] ? Q15_MIN : Q15_MAX;
      end else begin
         x_new = {adc_diff[11:0], 4'b0000};
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_item.cmd == CMD_SAMPLE && !taps_zero) begin
               state_in = ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            if (aligned) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (cnt_ff == LAST_POS) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_SCALE;
         ST_SCALE: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready         = 1'b0;
      cell_ctrl.samp_op = SAMP_HOLD;
      cell_ctrl.coef_op = COEF_HOLD;
      mac_ctrl.clear    = 1'b0;
      mac_ctrl.term     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               case (req_item.cmd)
                  CMD_SAMPLE: begin
                     if (!taps_zero) begin
                        cell_ctrl.samp_op = SAMP_SHIFT;
                        mac_ctrl.clear    = 1'b1;
                     end
                  end
                  CMD_COEF: begin
                     if (coef_ok) begin
                        cell_ctrl.coef_op = COEF_WRITE;
                     end
                  end
                  CMD_CLEAR: cell_ctrl.samp_op = SAMP_CLEAR;
                  default: ;
               endcase
            end
         end
         ST_ALIGN: begin
            if (!aligned) begin
               cell_ctrl.coef_op = COEF_ROTATE;
            end
         end
         ST_MAC: begin
            cell_ctrl.samp_op = SAMP_ROTATE;
            cell_ctrl.coef_op = COEF_ROTATE;
            mac_ctrl.term     = (TW'(cnt_ff) < taps_sat);
         end
         default: ;
      endcase
   end

   // scaling and DAC code
   assign shr = acc[ACC_W-1:15];
   always_comb begin
      if (shr > SH_MAX) begin
         y_in = Q15_MAX;
      end else if (shr < SH_MIN) begin
         y_in = Q15_MIN;
      end else begin
         y_in = shr[15:0];
      end
   end

   assign dac_sum = {{3{y_ff[15]}}, y_ff[15:4]} + {3'b000, dac_mid_ff};
   always_comb begin
      if (dac_sum[14]) begin
         dac_code = 12'd0;
      end else if (dac_sum[13:0] > {2'b00, dac_max_ff}) begin
         dac_code = dac_max_ff;
      end else begin
         dac_code = dac_sum[11:0];
      end
   end

   always_comb begin
      cnt_in       = (state_ff == ST_MAC) ? cnt_ff + 1'b1 : '0;
      rot_in       = rot_ff;
      if (state_ff == ST_ALIGN && !aligned) begin
         rot_in = (rot_ff == '0) ? LAST_POS : rot_ff - 1'b1;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in         = 1'b1;
         rsp_item_in.q15_out  = y_ff;
         rsp_item_in.dac_code = dac_code;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SCALE) begin
         y_ff <= y_in;
      end
      rsp_item_ff <= rsp_item_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rot_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rot_ff       <= rot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // row of tap cells
   logic signed [15:0] samp_q [MAX_TAPS];
   logic signed [15:0] coef_q [MAX_TAPS];

   for (genvar g = 0; g < MAX_TAPS; g++) begin : g_cell
      logic signed [15:0] samp_prev, samp_next, coef_prev;
      if (g == 0) begin : g_head
         assign samp_prev = x_new;
         assign coef_prev = coef_q[MAX_TAPS-1];
      end else begin : g_body
         assign samp_prev = samp_q[g-1];
         assign coef_prev = coef_q[g-1];
      end
      if (g == MAX_TAPS - 1) begin : g_tail
         assign samp_next = samp_q[0];
      end else begin : g_link
         assign samp_next = samp_q[g+1];
      end

      q15fir_cell #(
         .IDX_W (IDX_W),
         .POS   (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .wr_pos    (wr_pos),
         .wr_data   (req_item.coeff_value),
         .samp_prev (samp_prev),
         .samp_next (samp_next),
         .coef_prev (coef_prev),
         .samp_q    (samp_q[g]),
         .coef_q    (coef_q[g])
      );
   end

   q15fir_mac #(
      .ACC_W (ACC_W)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .samp  (samp_q[0]),
      .coef  (coef_q[0]),
      .acc   (acc)
   );

endmodule

// ----- hdl/q15fir_check.sv -----
// ----------------------------------------------------------------------------
// q15fir_check
// Port-level checks of the streaming Q15 FIR, bound to the top level.
// ----------------------------------------------------------------------------
module q15fir_check
   import q15fir_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input req_type               req_item,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_type               rsp_item,
   input logic                  csr_we,
   input logic [CSR_ADDR_W-1:0] csr_addr,
   input logic [CSR_DATA_W-1:0] csr_wdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result beat dropped or changed while stalled");

   a_non_sample_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_item.cmd != CMD_SAMPLE |=> req_ready)
      else $error("coefficient, clear or unused beat blocked the input");

   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result beat appeared without a busy cycle before it");

   a_busy_after_sample: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(req_valid && req_item.cmd == CMD_SAMPLE))
      else $error("input ready fell without an accepted sample beat");

endmodule

bind q15_fir_adc_dac_stream q15fir_check u_check (.*);

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: streaming Q15 FIR testbench
// Drives command beats (samples, coefficient loads, history clears) through
// the request channel with random gaps and random output back-pressure,
// predicts each filtered sample and DAC code in a scoreboard, and checks
// every result beat in order against it.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import q15fir_pkg::*;

   localparam int MAX_TAPS    = 128;
   localparam int SETTLE      = 2 * MAX_TAPS + 16;
   localparam int HOLD_CYCLES = 1000;
   localparam int LIMIT       = 2_000_000;
   localparam int ITEMS       = 550;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   class fir_scoreboard;
      logic signed [15:0] history [MAX_TAPS-1];
      logic signed [15:0] coeffs [MAX_TAPS];
      logic [7:0]         tap_count;
      logic               io_format;
      logic [11:0]        adc_mid;
      logic [11:0]        dac_mid;
      logic [11:0]        dac_max;
      rsp_type            results_due [$];
      int                 mismatches;

      function new();
         foreach (history[i]) history[i] = '0;
         foreach (coeffs[i]) coeffs[i] = '0;
         tap_count  = '0;
         io_format  = 1'b0;
         adc_mid    = 12'd2048;
         dac_mid    = 12'd2048;
         dac_max    = 12'd4095;
         mismatches = 0;
      endfunction

      function void write_register(logic [CSR_ADDR_W-1:0] addr,
                                   logic [CSR_DATA_W-1:0] data);
         case (addr)
            CSR_TAP_COUNT: tap_count = data[7:0];
            CSR_IO_FORMAT: io_format = data[0];
            CSR_ADC_MID:   adc_mid   = data[11:0];
            CSR_DAC_MID:   dac_mid   = data[11:0];
            CSR_DAC_MAX:   dac_max   = data[11:0];
            default: ;
         endcase
      endfunction

      function logic signed [15:0] sat_q15(longint v);
         if (v > longint'(Q15_MAX)) return Q15_MAX;
         if (v < longint'(Q15_MIN)) return Q15_MIN;
         return v[15:0];
      endfunction

      function void note_request(req_type r);
         int                 taps;
         int                 age;
         int                 yq;
         int                 dac;
         longint             acc;
         logic signed [15:0] x;
         logic signed [15:0] y;
         rsp_type            res;
         case (r.cmd)
            CMD_COEF: coeffs[r.coeff_index] = r.coeff_value;
            CMD_CLEAR: foreach (history[i]) history[i] = '0;
            CMD_SAMPLE: begin
               if (tap_count != 0) begin
                  taps = (tap_count > MAX_TAPS) ? MAX_TAPS : int'(tap_count);
                  if (io_format == 1'b0)
                     x = sat_q15(16 * (longint'(r.adc_code) - longint'(adc_mid)));
                  else
                     x = r.q15_in;
                  acc = 0;
                  for (int k = 0; k < taps; k++) begin
                     age = taps - 1 - k;
                     acc += longint'(age == 0 ? x : history[age-1]) * longint'(coeffs[k]);
                  end
                  y = sat_q15(acc >>> 15);
                  for (int i = MAX_TAPS - 2; i > 0; i--) history[i] = history[i-1];
                  history[0] = x;
                  yq  = y;
                  dac = (yq >>> 4) + int'(dac_mid);
                  if (dac < 0) dac = 0;
                  if (dac > int'(dac_max)) dac = int'(dac_max);
                  res.q15_out  = y;
                  res.dac_code = dac[11:0];
                  results_due.push_back(res);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (results_due.size() == 0) begin
            mismatches++;
            $display("%0t: result beat with none expected: q15_out %0d dac_code %0d",
                     $time, got.q15_out, got.dac_code);
            return;
         end
         want = results_due.pop_front();
         if (got.q15_out !== want.q15_out) begin
            mismatches++;
            $display("%0t: q15_out expected %0d actual %0d",
                     $time, want.q15_out, got.q15_out);
         end
         if (got.dac_code !== want.dac_code) begin
            mismatches++;
            $display("%0t: dac_code expected %0d actual %0d",
                     $time, want.dac_code, got.dac_code);
         end
      endfunction
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_item  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_item;
   logic                  csr_we    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bit            quiet    = 1'b0;
   bit            hold_rsp = 1'b0;
   fir_scoreboard sb;

   q15_fir_adc_dac_stream #(
      .MAX_TAPS (MAX_TAPS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (LIMIT) @(posedge clock);
      $display("tb NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.note_request(req_item);
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_item);
   end

   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (quiet || $urandom_range(0, 99) >= 14) begin
            rsp_ready <= 1'b1;
         end else begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 160) : $urandom_range(1, 6);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
   end

   function automatic req_type make_req(logic [1:0] cmd, logic [11:0] adc,
                                        logic signed [15:0] q15, logic [6:0] idx,
                                        logic signed [15:0] coef);
      req_type r;
      r.cmd         = cmd;
      r.adc_code    = adc;
      r.q15_in      = q15;
      r.coeff_index = idx;
      r.coeff_value = coef;
      return r;
   endfunction

   function automatic req_type random_req();
      req_type     r;
      logic [63:0] raw;
      int          pick;
      raw  = {$urandom, $urandom};
      r    = raw[$bits(req_type)-1:0];
      pick = $urandom_range(0, 99);
      if (pick < 72)      r.cmd = CMD_SAMPLE;
      else if (pick < 88) r.cmd = CMD_COEF;
      else if (pick < 95) r.cmd = CMD_CLEAR;
      else                r.cmd = CMD_UNUSED;
      case ($urandom_range(0, 7))
         0: r.adc_code = '0;
         1: r.adc_code = '1;
         default: ;
      endcase
      case ($urandom_range(0, 7))
         0: r.q15_in = Q15_MIN;
         1: r.q15_in = Q15_MAX;
         default: ;
      endcase
      case ($urandom_range(0, 5))
         0: r.coeff_value = Q15_MIN;
         1: r.coeff_value = Q15_MAX;
         2, 3: r.coeff_value = 16'(int'($urandom_range(0, 4095)) - 2048);
         default: ;
      endcase
      return r;
   endfunction

   function automatic int unsigned pick_code12();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 4095;
         default: return $urandom_range(0, 4095);
      endcase
   endfunction

   task automatic send_beat(input req_type r);
      req_valid <= 1'b1;
      req_item  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic sender_gap();
      int n;
      if (!quiet && $urandom_range(0, 99) < 14) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 160) : $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained(input bit settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.results_due.size() != 0) @(posedge clock);
      if (settle) repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input int unsigned data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_register(addr, data[CSR_DATA_W-1:0]);
      @(posedge clock);
   endtask

   initial begin
      req_type     r;
      int          counted;
      int          phase;
      int          len;
      int unsigned taps;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // drop a sample at zero taps, load coefficients, try the unused command
      send_beat(make_req(CMD_SAMPLE, 12'hFFF, Q15_MAX, 7'd0, 16'sd0));
      send_beat(make_req(CMD_COEF, 12'd0, 16'sd0, 7'd0, Q15_MAX));
      send_beat(make_req(CMD_COEF, 12'd0, 16'sd0, 7'd1, Q15_MIN));
      send_beat(make_req(CMD_COEF, 12'd0, 16'sd0, 7'd2, 16'sd16384));
      send_beat(make_req(CMD_COEF, 12'd0, 16'sd0, 7'd127, -16'sd1));
      send_beat(make_req(CMD_UNUSED, 12'hFFF, -16'sd1, 7'h7F, -16'sd1));
      wait_drained(1'b1);
      write_csr(CSR_TAP_COUNT, 3);

      send_beat(make_req(CMD_SAMPLE, 12'd0, 16'sd0, 7'd0, 16'sd0));
      send_beat(make_req(CMD_SAMPLE, 12'hFFF, 16'sd0, 7'd0, 16'sd0));
      send_beat(make_req(CMD_SAMPLE, 12'd2048, 16'sd0, 7'd0, 16'sd0));
      send_beat(make_req(CMD_SAMPLE, 12'd1, 16'sd0, 7'd0, 16'sd0));
      send_beat(make_req(CMD_CLEAR, 12'd0, 16'sd0, 7'd0, 16'sd0));
      send_beat(make_req(CMD_SAMPLE, 12'hFFF, 16'sd0, 7'd0, 16'sd0));
      wait_drained(1'b1);
      write_csr(CSR_ADC_MID, 4095);
      write_csr(CSR_DAC_MAX, 100);

      send_beat(make_req(CMD_SAMPLE, 12'd0, 16'sd0, 7'd0, 16'sd0));
      send_beat(make_req(CMD_SAMPLE, 12'hFFF, 16'sd0, 7'd0, 16'sd0));
      wait_drained(1'b1);
      write_csr(CSR_IO_FORMAT, 1);
      write_csr(CSR_TAP_COUNT, 200);
      write_csr(CSR_DAC_MID, 4095);
      write_csr(CSR_DAC_MAX, 4095);

      // saturate the output both ways through the newest taps
      send_beat(make_req(CMD_COEF, 12'd0, 16'sd0, 7'd126, Q15_MAX));
      send_beat(make_req(CMD_COEF, 12'd0, 16'sd0, 7'd127, Q15_MAX));
      send_beat(make_req(CMD_SAMPLE, 12'd0, Q15_MAX, 7'd0, 16'sd0));
      send_beat(make_req(CMD_SAMPLE, 12'd0, Q15_MAX, 7'd0, 16'sd0));
      send_beat(make_req(CMD_SAMPLE, 12'd0, Q15_MIN, 7'd0, 16'sd0));
      send_beat(make_req(CMD_SAMPLE, 12'd0, Q15_MIN, 7'd0, 16'sd0));
      send_beat(make_req(CMD_SAMPLE, 12'd0, 16'sd0, 7'd0, 16'sd0));
      wait_drained(1'b1);

      counted = 0;
      phase   = 0;
      while (counted < ITEMS) begin
         case (phase)
            0: taps = MAX_TAPS;
            1: taps = 8;
            2: taps = 1;
            4: taps = 0;
            5: taps = 255;
            default: begin
               case ($urandom_range(0, 9))
                  0: taps = 1;
                  1: taps = MAX_TAPS;
                  2: taps = $urandom_range(MAX_TAPS + 1, 255);
                  3: taps = 0;
                  default: taps = $urandom_range(2, 24);
               endcase
            end
         endcase
         write_csr(CSR_TAP_COUNT, taps);
         write_csr(CSR_IO_FORMAT, $urandom_range(0, 1));
         write_csr(CSR_ADC_MID, pick_code12());
         write_csr(CSR_DAC_MID, pick_code12());
         write_csr(CSR_DAC_MAX, pick_code12());
         if (phase == 1) hold_rsp = 1'b1;
         quiet = (phase == 3);
         len   = (taps == 0) ? 12 : $urandom_range(30, 70);
         for (int i = 0; i < len; i++) begin
            sender_gap();
            r = random_req();
            send_beat(r);
            if (!(r.cmd == CMD_UNUSED || (r.cmd == CMD_SAMPLE && taps == 0))) counted++;
            if ($urandom_range(0, 49) == 0) wait_drained(1'b0);
         end
         quiet = 1'b0;
         wait_drained(1'b1);
         phase++;
      end

      if (sb.mismatches == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
